/* src/assert_macros.svh */
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while in reset
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication, off while in reset
`define UTF8D_IMPLY(lbl, ante, cons, msg) \
  `UTF8D_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* src/utf8d_pkg.sv */
// types, constants and lead-byte helpers for the utf-8 decoder
package utf8d_pkg;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam logic [20:0] MAX_CP    = 21'h10FFFF;
  localparam logic [2:0]  AVAIL_MAX = 3'd4;
  localparam logic [7:0]  CONT_LO   = 8'h80;
  localparam logic [7:0]  CONT_HI   = 8'hBF;

  // accept range of the second byte, picked by the lead byte
  typedef enum logic [2:0] {
    RNG_ANY,
    RNG_E0,
    RNG_ED,
    RNG_F0,
    RNG_F4
  } range_t;

  // raw window as it arrives
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic [2:0] avail_count;
  } win_t;

  // after lead-byte classification
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] avail;
    logic [2:0] seq_len;
    range_t     rng;
    logic       ascii;
    logic       bad_lead;
    logic       empty;
  } cls_t;

  // after validation
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] width;
    logic       ok;
  } chk_t;

  // decoded result
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  consumed;
  } res_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= CONT_LO) && (b <= CONT_HI);
  endfunction

endpackage

/* src/utf8d_ifs.sv */
// valid/ready channel interfaces for the decoder window and result
interface utf8d_win_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  logic [2:0] avail_count;

  modport source (output valid, byte_first, byte_second, byte_third, byte_fourth,
                  avail_count, input ready);
  modport sink (input valid, byte_first, byte_second, byte_third, byte_fourth,
                avail_count, output ready);
endinterface

interface utf8d_res_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  consumed;

  modport source (output valid, code_point, consumed, input ready);
  modport sink (input valid, code_point, consumed, output ready);
endinterface

/* src/utf8d_classify.sv */
// stage 1: clip the byte count and classify the lead byte
module utf8d_classify (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf8d_pkg::win_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8d_pkg::cls_t out_data
);
  import utf8d_pkg::*;

  logic vld;
  cls_t stage;
  cls_t stage_next;
  logic [7:0] lead;

  assign lead = in_data.byte_first;

  always_comb begin
    stage_next          = '0;
    stage_next.b0       = in_data.byte_first;
    stage_next.b1       = in_data.byte_second;
    stage_next.b2       = in_data.byte_third;
    stage_next.b3       = in_data.byte_fourth;
    stage_next.avail    = (in_data.avail_count > AVAIL_MAX) ? AVAIL_MAX : in_data.avail_count;
    stage_next.empty    = (in_data.avail_count == 3'd0);
    stage_next.rng      = RNG_ANY;
    stage_next.seq_len  = 3'd1;
    stage_next.ascii    = 1'b0;
    stage_next.bad_lead = 1'b0;
    if (lead < 8'h80) begin
      stage_next.ascii = 1'b1;
    end else if (lead < 8'hC2) begin
      stage_next.bad_lead = 1'b1;
    end else if (lead < 8'hE0) begin
      stage_next.seq_len = 3'd2;
    end else if (lead == 8'hE0) begin
      stage_next.seq_len = 3'd3;
      stage_next.rng     = RNG_E0;
    end else if (lead == 8'hED) begin
      stage_next.seq_len = 3'd3;
      stage_next.rng     = RNG_ED;
    end else if (lead < 8'hF0) begin
      stage_next.seq_len = 3'd3;
    end else if (lead == 8'hF0) begin
      stage_next.seq_len = 3'd4;
      stage_next.rng     = RNG_F0;
    end else if (lead < 8'hF4) begin
      stage_next.seq_len = 3'd4;
    end else if (lead == 8'hF4) begin
      stage_next.seq_len = 3'd4;
      stage_next.rng     = RNG_F4;
    end else begin
      stage_next.bad_lead = 1'b1;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = stage;

endmodule

/* src/utf8d_check.sv */
// stage 2: validate continuation bytes and settle the width
module utf8d_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf8d_pkg::cls_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8d_pkg::chk_t out_data
);
  import utf8d_pkg::*;

  logic vld;
  chk_t stage;
  chk_t stage_next;
  logic [7:0] sec_lo;
  logic [7:0] sec_hi;
  logic sec_ok;

  always_comb begin
    case (in_data.rng)
      RNG_ANY: begin sec_lo = 8'h80; sec_hi = 8'hBF; end
      RNG_E0:  begin sec_lo = 8'hA0; sec_hi = 8'hBF; end
      RNG_ED:  begin sec_lo = 8'h80; sec_hi = 8'h9F; end
      RNG_F0:  begin sec_lo = 8'h90; sec_hi = 8'hBF; end
      RNG_F4:  begin sec_lo = 8'h80; sec_hi = 8'h8F; end
      default: begin sec_lo = 8'hFF; sec_hi = 8'h00; end
    endcase
  end

  assign sec_ok = (in_data.b1 >= sec_lo) && (in_data.b1 <= sec_hi);

  always_comb begin
    stage_next.b0    = in_data.b0;
    stage_next.b1    = in_data.b1;
    stage_next.b2    = in_data.b2;
    stage_next.b3    = in_data.b3;
    stage_next.width = 3'd1;
    stage_next.ok    = 1'b0;
    if (in_data.empty) begin
      stage_next.width = 3'd0;
    end else if (in_data.ascii) begin
      stage_next.ok = 1'b1;
    end else if (in_data.bad_lead || (in_data.avail < in_data.seq_len) || !sec_ok) begin
      stage_next.ok = 1'b0;
    end else if (in_data.seq_len == 3'd2) begin
      stage_next.width = 3'd2;
      stage_next.ok    = 1'b1;
    end else if (!is_cont(in_data.b2)) begin
      stage_next.ok = 1'b0;
    end else if (in_data.seq_len == 3'd3) begin
      stage_next.width = 3'd3;
      stage_next.ok    = 1'b1;
    end else if (!is_cont(in_data.b3)) begin
      stage_next.ok = 1'b0;
    end else begin
      stage_next.width = 3'd4;
      stage_next.ok    = 1'b1;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = stage;

endmodule

/* src/utf8d_assemble.sv */
// stage 3: pack the payload bits into the code point, output register
module utf8d_assemble (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf8d_pkg::chk_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8d_pkg::res_t out_data
);
  import utf8d_pkg::*;

  logic vld;
  res_t stage;
  res_t stage_next;

  always_comb begin
    stage_next.consumed   = in_data.width;
    stage_next.code_point = REPL_CP;
    if (in_data.ok) begin
      case (in_data.width)
        3'd1: stage_next.code_point = {13'd0, in_data.b0};
        3'd2: stage_next.code_point = {10'd0, in_data.b0[4:0], in_data.b1[5:0]};
        3'd3: stage_next.code_point = {5'd0, in_data.b0[3:0], in_data.b1[5:0],
                                       in_data.b2[5:0]};
        3'd4: stage_next.code_point = {in_data.b0[2:0], in_data.b1[5:0],
                                       in_data.b2[5:0], in_data.b3[5:0]};
        default: stage_next.code_point = REPL_CP;
      endcase
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = stage;

endmodule

/* src/utf8_codepoint_decoder.sv */
// utf-8 code point decoder: three-stage pipeline, top level
// Usage:
//   win carries one beat per window: four bytes, first byte is the lead, and
//   avail_count telling how many of them are valid (5..7 act as 4).
//   dec returns one beat per window: the code point and the bytes consumed.
//   Invalid or truncated sequences return U+FFFD with consumed 1; an empty
//   window returns U+FFFD with consumed 0. Bytes past the sequence are ignored.
// Timing:
//   Three register stages (classify, check, assemble); a window accepted on
//   win passes through them in order to dec. One window per cycle sustained
//   while dec.ready is high; each stage holds one beat.
// Reset:
//   rst clears every stage valid bit; no beat is in flight afterward.
// Stall:
//   when dec.ready is low each full stage holds its beat and win.ready drops
//   once the pipeline is full; nothing is dropped or repeated.
`include "assert_macros.svh"

module utf8_codepoint_decoder (
  input logic       clk,
  input logic       rst,
  utf8d_win_if.sink win,
  utf8d_res_if.source dec
);
  import utf8d_pkg::*;

  win_t win_data;
  cls_t cls_data;
  chk_t chk_data;
  res_t res_data;
  logic cls_valid;
  logic cls_ready;
  logic chk_valid;
  logic chk_ready;

  assign win_data.byte_first  = win.byte_first;
  assign win_data.byte_second = win.byte_second;
  assign win_data.byte_third  = win.byte_third;
  assign win_data.byte_fourth = win.byte_fourth;
  assign win_data.avail_count = win.avail_count;

  utf8d_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win.valid),
    .in_ready  (win.ready),
    .in_data   (win_data),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_data  (cls_data)
  );

  utf8d_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_data   (cls_data),
    .out_valid (chk_valid),
    .out_ready (chk_ready),
    .out_data  (chk_data)
  );

  utf8d_assemble u_assemble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_data   (chk_data),
    .out_valid (dec.valid),
    .out_ready (dec.ready),
    .out_data  (res_data)
  );

  assign dec.code_point = res_data.code_point;
  assign dec.consumed   = res_data.consumed;

  // empty window always reports the replacement character
  `UTF8D_IMPLY(a_empty_repl, dec.valid && (dec.consumed == 3'd0),
               dec.code_point == REPL_CP, "empty window without U+FFFD")
  // a one-byte result is either ascii or the replacement character
  `UTF8D_IMPLY(a_one_byte, dec.valid && (dec.consumed == 3'd1),
               (dec.code_point < 21'h80) || (dec.code_point == REPL_CP),
               "one-byte result out of range")
  // decoded values are scalar values only
  `UTF8D_IMPLY(a_scalar, dec.valid,
               (dec.code_point <= MAX_CP) &&
               ((dec.code_point < 21'hD800) || (dec.code_point > 21'hDFFF)),
               "surrogate or out-of-range code point")
  // width never exceeds four bytes
  `UTF8D_IMPLY(a_width, dec.valid, dec.consumed <= AVAIL_MAX, "consumed above four")
  // a check-stage beat with a multi-byte width must be valid utf-8
  `UTF8D_IMPLY(a_chk_ok, chk_valid && (chk_data.width > 3'd1), chk_data.ok,
               "multi-byte width on a rejected sequence")

endmodule
